// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain clocked assertion, disabled while reset is asserted
`define LRR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// overlapping implication built on the plain form
`define LRR_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    `LRR_ASSERT(label, clk, rst_n, (ante) |-> (cons), msg)

`endif

// ===== hw/rtl/lrr_pkg.sv =====
// types and constants of the link reconnect retry block
`default_nettype none

package lrr_pkg;

    // configuration port geometry
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LINK_ENABLED        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_INTERVAL      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRIES         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_AP_FALLBACK         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CREDENTIALS_PRESENT = 3'd4;

    // configuration reset values
    localparam logic [15:0] RETRY_INTERVAL_RST = 16'd10;
    localparam logic [7:0]  MAX_RETRIES_RST    = 8'd5;

    // saturation value of the seconds counter
    localparam logic [15:0] SECS_MAX = 16'hFFFF;

    typedef enum logic [2:0] {
        MODE_DISABLED     = 3'd0,
        MODE_DISCONNECTED = 3'd1,
        MODE_CONNECTING   = 3'd2,
        MODE_CONNECTED    = 3'd3,
        MODE_AP           = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        REQ_TICK          = 3'd0,
        REQ_CONNECT_NOW   = 3'd1,
        REQ_DISCONNECT    = 3'd2,
        REQ_LINK_LOST     = 3'd3,
        REQ_RESET_RETRIES = 3'd4,
        REQ_ENABLE        = 3'd5
    } req_t;

    typedef struct packed {
        logic        link_enabled;
        logic [15:0] retry_interval;
        logic [7:0]  max_retries;
        logic        ap_fallback;
        logic        credentials_present;
    } cfg_t;

    typedef struct packed {
        mode_t       mode;
        logic [15:0] secs;
        logic [7:0]  retries;
    } state_t;

    typedef struct packed {
        logic [2:0] req_type;
        logic       enable_value;
        logic       link_up;
        logic       attempt_ok;
    } in_item_t;

    typedef struct packed {
        mode_t      mode;
        logic       connected;
        logic       attempt_issued;
        logic       connect_result;
        logic       start_access_point;
        logic       radio_off;
        logic [7:0] retries_used;
    } res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lrr_cfg_regs.sv =====
// configuration register file of the link reconnect retry block
`default_nettype none

module lrr_cfg_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [lrr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [lrr_pkg::CFG_DATA_W-1:0] cfg_data,
    output lrr_pkg::cfg_t                       cfg
);
    import lrr_pkg::*;

    cfg_t cfg_reg;

    // register writes, no read-back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.link_enabled        <= 1'b0;
            cfg_reg.retry_interval      <= RETRY_INTERVAL_RST;
            cfg_reg.max_retries         <= MAX_RETRIES_RST;
            cfg_reg.ap_fallback         <= 1'b0;
            cfg_reg.credentials_present <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LINK_ENABLED:        cfg_reg.link_enabled        <= cfg_data[0];
                CFG_RETRY_INTERVAL:      cfg_reg.retry_interval      <= cfg_data[15:0];
                CFG_MAX_RETRIES:         cfg_reg.max_retries         <= cfg_data[7:0];
                CFG_AP_FALLBACK:         cfg_reg.ap_fallback         <= cfg_data[0];
                CFG_CREDENTIALS_PRESENT: cfg_reg.credentials_present <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/lrr_step.sv =====
// next state and result for one request
`default_nettype none

module lrr_step (
    input  wire lrr_pkg::cfg_t     cfg,
    input  wire lrr_pkg::state_t   st,
    input  wire lrr_pkg::in_item_t item,
    output lrr_pkg::state_t        st_next,
    output lrr_pkg::res_t          res
);
    import lrr_pkg::*;

    always_comb
    begin
        mode_t       md;
        logic [15:0] secs;
        logic [7:0]  rc;
        logic        issued;
        logic        result;
        logic        start_ap;
        logic        off;

        md       = st.mode;
        secs     = st.secs;
        rc       = st.retries;
        issued   = 1'b0;
        result   = 1'b0;
        start_ap = 1'b0;
        off      = 1'b0;

        case (req_t'(item.req_type))
            REQ_TICK:
            begin
                if (!cfg.link_enabled)
                begin
                    md = MODE_DISABLED;
                end
                else
                begin
                    // dropped link seen on a tick
                    if (md == MODE_CONNECTED && !item.link_up)
                    begin
                        md   = MODE_DISCONNECTED;
                        secs = cfg.retry_interval;
                    end
                    if (!(md inside {MODE_AP, MODE_CONNECTED}))
                    begin
                        if (secs != SECS_MAX)
                            secs = secs + 16'd1;
                        // retry interval elapsed
                        if (cfg.credentials_present && secs >= cfg.retry_interval)
                        begin
                            secs = '0;
                            if (rc >= cfg.max_retries)
                            begin
                                if (cfg.ap_fallback)
                                begin
                                    start_ap = 1'b1;
                                    md       = MODE_AP;
                                end
                            end
                            else
                            begin
                                rc     = rc + 8'd1;
                                issued = 1'b1;
                                if (item.attempt_ok)
                                begin
                                    md     = MODE_CONNECTED;
                                    result = 1'b1;
                                    rc     = '0;
                                end
                                else
                                begin
                                    md = MODE_DISCONNECTED;
                                end
                            end
                        end
                    end
                end
            end
            REQ_CONNECT_NOW:
            begin
                if (!cfg.link_enabled)
                begin
                    md = MODE_DISABLED;
                end
                else if (!cfg.credentials_present)
                begin
                    md = MODE_DISCONNECTED;
                end
                else
                begin
                    issued = 1'b1;
                    if (item.attempt_ok)
                    begin
                        md     = MODE_CONNECTED;
                        secs   = '0;
                        result = 1'b1;
                    end
                    else
                    begin
                        md = MODE_DISCONNECTED;
                    end
                end
            end
            REQ_DISCONNECT:
            begin
                md = MODE_DISCONNECTED;
            end
            REQ_LINK_LOST:
            begin
                if (!(md inside {MODE_DISABLED, MODE_AP}))
                begin
                    md   = MODE_DISCONNECTED;
                    secs = cfg.retry_interval;
                end
            end
            REQ_RESET_RETRIES:
            begin
                rc   = '0;
                secs = '0;
            end
            REQ_ENABLE:
            begin
                if (item.enable_value)
                begin
                    if (cfg.link_enabled && md == MODE_DISABLED)
                        md = MODE_DISCONNECTED;
                end
                else
                begin
                    md  = MODE_DISABLED;
                    off = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        st_next.mode    = md;
        st_next.secs    = secs;
        st_next.retries = rc;

        res.mode               = md;
        res.connected          = (md == MODE_CONNECTED) && item.link_up;
        res.attempt_issued     = issued;
        res.connect_result     = result;
        res.start_access_point = start_ap;
        res.radio_off          = off;
        res.retries_used       = rc;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/link_reconnect_retry_fsm.sv =====
// top level of the link reconnect retry block
//
//  channel   direction  handshake           payload
//  request   in         in_valid/in_ready   req_type enable_value link_up attempt_ok
//  result    out        out_valid/out_ready mode connected attempt_issued connect_result
//                                           start_access_point radio_off retries_used
//  config    in         cfg_we              cfg_index cfg_data
//
// one request per cycle while the result side is not stalled; a request passes through
// the request register, then the result register
// the link state is updated as a request moves from the request register
// into the result register, so back to back requests see each other's effect
// a stalled result holds the request register; it still takes one more request
// asynchronous active-low reset restores the link state and register defaults
`default_nettype none

module link_reconnect_retry_fsm (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [2:0]                     req_type,
    input  wire logic                           enable_value,
    input  wire logic                           link_up,
    input  wire logic                           attempt_ok,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [2:0]                          mode,
    output logic                                connected,
    output logic                                attempt_issued,
    output logic                                connect_result,
    output logic                                start_access_point,
    output logic                                radio_off,
    output logic [7:0]                          retries_used,
    input  wire logic                           cfg_we,
    input  wire logic [lrr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [lrr_pkg::CFG_DATA_W-1:0] cfg_data
);
    import lrr_pkg::*;

    cfg_t     cfg;
    state_t   state_reg;
    state_t   state_next;
    in_item_t item_reg;
    logic     item_valid_reg;
    res_t     res_reg;
    res_t     res_next;
    logic     out_valid_reg;
    logic     advance;

    lrr_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lrr_step u_step (
        .cfg     (cfg),
        .st      (state_reg),
        .item    (item_reg),
        .st_next (state_next),
        .res     (res_next)
    );

    // flow control between the two register stages
    assign advance  = item_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !item_valid_reg || advance;

    // request register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (in_ready)
            item_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg.req_type     <= req_type;
            item_reg.enable_value <= enable_value;
            item_reg.link_up      <= link_up;
            item_reg.attempt_ok   <= attempt_ok;
        end
    end

    // link state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode    <= MODE_DISABLED;
            state_reg.secs    <= '0;
            state_reg.retries <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res_next;
    end

    // result ports
    assign out_valid          = out_valid_reg;
    assign mode               = res_reg.mode;
    assign connected          = res_reg.connected;
    assign attempt_issued     = res_reg.attempt_issued;
    assign connect_result     = res_reg.connect_result;
    assign start_access_point = res_reg.start_access_point;
    assign radio_off          = res_reg.radio_off;
    assign retries_used       = res_reg.retries_used;

endmodule

`default_nettype wire

// ===== hw/rtl/lrr_checker.sv =====
// port-level checks of the link reconnect retry block and their binding
`default_nettype none

`include "assert_macros.svh"

module lrr_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [2:0] mode,
    input wire logic       connected,
    input wire logic       attempt_issued,
    input wire logic       connect_result,
    input wire logic       start_access_point,
    input wire logic       radio_off,
    input wire logic [7:0] retries_used
);
    import lrr_pkg::*;

    // connected status only in connected mode
    `LRR_ASSERT_IMPLY(a_connected_mode, clk, rst_n, out_valid && connected, mode == MODE_CONNECTED, "connected outside connected mode")

    // a successful attempt leaves the link connected
    `LRR_ASSERT_IMPLY(a_result_ok, clk, rst_n, out_valid && connect_result, attempt_issued && mode == MODE_CONNECTED, "connect result without connected attempt")

    // a failed attempt leaves the link disconnected
    `LRR_ASSERT_IMPLY(a_result_fail, clk, rst_n, out_valid && attempt_issued && !connect_result, mode == MODE_DISCONNECTED, "failed attempt not disconnected")

    // fallback and radio-off commands match the reported mode
    `LRR_ASSERT_IMPLY(a_cmd_mode, clk, rst_n, out_valid && (start_access_point || radio_off), (start_access_point && !radio_off && !attempt_issued && mode == MODE_AP) || (radio_off && !start_access_point && mode == MODE_DISABLED), "command does not match mode")

    // a stalled transaction holds its retry count
    `LRR_ASSERT(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> (out_valid && $stable(retries_used)), "stalled result changed")

endmodule

bind link_reconnect_retry_fsm lrr_checker u_lrr_checker (.*);

`default_nettype wire

// ===== bench/link_reconnect_retry_fsm_test.sv =====
// self-checking bench for the link reconnect retry block: random and directed requests
module link_reconnect_retry_fsm_test;

    import lrr_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int LONG_HOLD   = 300;
    localparam int RAND_PHASES = 14;
    localparam int PHASE_ITEMS = 115;

    // request codes the block leaves unused
    localparam logic [2:0] REQ_SPARE_LO = 3'd6;
    localparam logic [2:0] REQ_SPARE_HI = 3'd7;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  in_valid     = 1'b0;
    logic                  in_ready;
    logic [2:0]            req_type     = '0;
    logic                  enable_value = 1'b0;
    logic                  link_up      = 1'b0;
    logic                  attempt_ok   = 1'b0;
    logic                  out_valid;
    logic                  out_ready    = 1'b0;
    logic [2:0]            mode;
    logic                  connected;
    logic                  attempt_issued;
    logic                  connect_result;
    logic                  start_access_point;
    logic                  radio_off;
    logic [7:0]            retries_used;
    logic                  cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;

    link_reconnect_retry_fsm u_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .req_type           (req_type),
        .enable_value       (enable_value),
        .link_up            (link_up),
        .attempt_ok         (attempt_ok),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .mode               (mode),
        .connected          (connected),
        .attempt_issued     (attempt_issued),
        .connect_result     (connect_result),
        .start_access_point (start_access_point),
        .radio_off          (radio_off),
        .retries_used       (retries_used),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shadow copy of the link state and registers
    cfg_t        shadow_cfg;
    mode_t       pred_mode;
    logic [15:0] pred_secs;
    logic [7:0]  pred_retries;

    in_item_t    pending_reqs[$];
    res_t        expected_status[$];
    in_item_t    cur_item;
    res_t        want;
    int          n_queued   = 0;
    int          n_checked  = 0;
    int          n_results  = 0;
    int          mismatches = 0;
    int          drive_gap  = 0;
    int          hold_left  = 0;
    int          cycles     = 0;
    bit          calm       = 1'b0;

    // one connect operation on the shadow state
    function automatic void try_attempt(input logic ok, output logic issued,
                                        output logic result);
        issued = 1'b0;
        result = 1'b0;
        if (!shadow_cfg.link_enabled)
            pred_mode = MODE_DISABLED;
        else if (!shadow_cfg.credentials_present)
            pred_mode = MODE_DISCONNECTED;
        else
        begin
            issued = 1'b1;
            if (ok)
            begin
                pred_mode = MODE_CONNECTED;
                pred_secs = '0;
                result    = 1'b1;
            end
            else
                pred_mode = MODE_DISCONNECTED;
        end
    endfunction

    // dropped link, ignored while disabled or serving as access point
    function automatic void drop_link();
        if (pred_mode != MODE_DISABLED && pred_mode != MODE_AP)
        begin
            pred_mode = MODE_DISCONNECTED;
            pred_secs = shadow_cfg.retry_interval;
        end
    endfunction

    // next link status for one request
    function automatic res_t step_link(in_item_t it);
        res_t r;
        logic issued;
        logic result;
        logic start_ap;
        logic off;
        issued   = 1'b0;
        result   = 1'b0;
        start_ap = 1'b0;
        off      = 1'b0;
        case (it.req_type)
            REQ_TICK:
            begin
                if (!shadow_cfg.link_enabled)
                    pred_mode = MODE_DISABLED;
                else
                begin
                    if (pred_mode == MODE_CONNECTED && !it.link_up)
                        drop_link();
                    if (pred_mode != MODE_AP && pred_mode != MODE_CONNECTED)
                    begin
                        if (pred_secs < SECS_MAX)
                            pred_secs = pred_secs + 16'd1;
                        if (shadow_cfg.credentials_present &&
                            pred_secs >= shadow_cfg.retry_interval)
                        begin
                            pred_secs = '0;
                            if (pred_retries >= shadow_cfg.max_retries)
                            begin
                                if (shadow_cfg.ap_fallback)
                                begin
                                    start_ap  = 1'b1;
                                    pred_mode = MODE_AP;
                                end
                            end
                            else
                            begin
                                pred_retries = pred_retries + 8'd1;
                                try_attempt(it.attempt_ok, issued, result);
                                if (pred_mode == MODE_CONNECTED)
                                    pred_retries = '0;
                            end
                        end
                    end
                end
            end
            REQ_CONNECT_NOW:
                try_attempt(it.attempt_ok, issued, result);
            REQ_DISCONNECT:
                pred_mode = MODE_DISCONNECTED;
            REQ_LINK_LOST:
                drop_link();
            REQ_RESET_RETRIES:
            begin
                pred_retries = '0;
                pred_secs    = '0;
            end
            REQ_ENABLE:
            begin
                if (it.enable_value)
                begin
                    if (shadow_cfg.link_enabled && pred_mode == MODE_DISABLED)
                        pred_mode = MODE_DISCONNECTED;
                end
                else
                begin
                    pred_mode = MODE_DISABLED;
                    off       = 1'b1;
                end
            end
            default: ;
        endcase
        r.mode               = pred_mode;
        r.connected          = (pred_mode == MODE_CONNECTED) && it.link_up;
        r.attempt_issued     = issued;
        r.connect_result     = result;
        r.start_access_point = start_ap;
        r.radio_off          = off;
        r.retries_used       = pred_retries;
        return r;
    endfunction

    // register write as seen by the shadow copy
    function automatic void store_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        case (idx)
            CFG_LINK_ENABLED:        shadow_cfg.link_enabled        = val[0];
            CFG_RETRY_INTERVAL:      shadow_cfg.retry_interval      = val;
            CFG_MAX_RETRIES:         shadow_cfg.max_retries         = val[7:0];
            CFG_AP_FALLBACK:         shadow_cfg.ap_fallback         = val[0];
            CFG_CREDENTIALS_PRESENT: shadow_cfg.credentials_present = val[0];
            default: ;
        endcase
    endfunction

    // wait cycles drawn per transaction
    function automatic int draw_wait();
        if (calm || $urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(0, 19);
    endfunction

    function automatic void check_field(string name, int unsigned exp_val,
                                        int unsigned act_val);
        if (exp_val != act_val)
        begin
            $display("%0t: %s expected %0d got %0d", $time, name, exp_val, act_val);
            mismatches++;
        end
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        store_reg(idx, val);
    endtask

    // all five registers, junk in the unused upper bits
    task automatic apply_config(input logic le, input logic [15:0] interval,
                                input logic [7:0] max_r, input logic ap, input logic creds);
        write_reg(CFG_LINK_ENABLED, {15'($urandom()), le});
        write_reg(CFG_RETRY_INTERVAL, interval);
        write_reg(CFG_MAX_RETRIES, {8'($urandom()), max_r});
        write_reg(CFG_AP_FALLBACK, {15'($urandom()), ap});
        write_reg(CFG_CREDENTIALS_PRESENT, {15'($urandom()), creds});
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic queue_req(input logic [2:0] req, input logic ev, input logic up,
                             input logic ok);
        in_item_t it;
        it.req_type     = req;
        it.enable_value = ev;
        it.link_up      = up;
        it.attempt_ok   = ok;
        pending_reqs.push_back(it);
        n_queued++;
    endtask

    // every queued request answered, then a margin of idle clocks
    task automatic wait_idle();
        while (n_checked != n_queued)
            @(posedge clk);
        repeat (3) @(posedge clk);
        calm = ($urandom_range(0, 3) == 0);
    endtask

    // mostly well-formed traffic: enable first, then ticks with some commands
    task automatic queue_random_phase(input int count, input bit noisy);
        int         pick;
        logic [2:0] req;
        logic       ev;
        queue_req(REQ_ENABLE, 1'b1, 1'($urandom()), 1'($urandom()));
        for (int i = 1; i < count; i++)
        begin
            ev   = 1'($urandom());
            pick = $urandom_range(0, 99);
            if (noisy || $urandom_range(0, 9) == 0)
                req = 3'($urandom_range(0, 7));
            else if (pick < 65)
                req = REQ_TICK;
            else if (pick < 73)
                req = REQ_CONNECT_NOW;
            else if (pick < 78)
                req = REQ_DISCONNECT;
            else if (pick < 85)
                req = REQ_LINK_LOST;
            else if (pick < 90)
                req = REQ_RESET_RETRIES;
            else if (pick < 97)
            begin
                req = REQ_ENABLE;
                ev  = ($urandom_range(0, 3) != 0);
            end
            else
                req = ($urandom_range(0, 1) == 0) ? REQ_SPARE_LO : REQ_SPARE_HI;
            queue_req(req, ev, ($urandom_range(0, 3) != 0), 1'($urandom()));
        end
    endtask

    // request driver, predicts each accepted transaction
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_status.push_back(step_link(cur_item));
                drive_gap = draw_wait();
            end
            if (in_valid && !in_ready)
                ;
            else if (drive_gap > 0)
            begin
                drive_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_reqs.size() > 0)
            begin
                cur_item = pending_reqs.pop_front();
                req_type     <= cur_item.req_type;
                enable_value <= cur_item.enable_value;
                link_up      <= cur_item.link_up;
                attempt_ok   <= cur_item.attempt_ok;
                in_valid     <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result monitor with random stalls and two long hold-offs
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                n_results++;
                if (expected_status.size() == 0)
                begin
                    $display("%0t: result transaction with nothing expected", $time);
                    mismatches++;
                end
                else
                begin
                    want = expected_status.pop_front();
                    n_checked++;
                    check_field("mode", want.mode, mode);
                    check_field("connected", want.connected, connected);
                    check_field("attempt_issued", want.attempt_issued, attempt_issued);
                    check_field("connect_result", want.connect_result, connect_result);
                    check_field("start_access_point", want.start_access_point,
                                start_access_point);
                    check_field("radio_off", want.radio_off, radio_off);
                    check_field("retries_used", want.retries_used, retries_used);
                end
                hold_left = draw_wait();
                if (n_results == 400 || n_results == 1300)
                    hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // phases of configuration and stimulus
    initial
    begin
        logic [15:0] interval;
        logic [7:0]  max_r;
        int          pick;

        shadow_cfg.link_enabled        = 1'b0;
        shadow_cfg.retry_interval      = RETRY_INTERVAL_RST;
        shadow_cfg.max_retries         = MAX_RETRIES_RST;
        shadow_cfg.ap_fallback         = 1'b0;
        shadow_cfg.credentials_present = 1'b0;
        pred_mode    = MODE_DISABLED;
        pred_secs    = '0;
        pred_retries = '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // defaults: everything refused or ignored while not enabled
        queue_req(REQ_TICK, 1'b0, 1'b0, 1'b0);
        queue_req(REQ_CONNECT_NOW, 1'b0, 1'b1, 1'b1);
        queue_req(REQ_ENABLE, 1'b1, 1'b0, 1'b0);
        queue_req(REQ_LINK_LOST, 1'b0, 1'b0, 1'b0);
        queue_req(REQ_SPARE_LO, 1'b0, 1'b0, 1'b0);
        queue_req(REQ_SPARE_HI, 1'b1, 1'b1, 1'b1);
        queue_req(REQ_ENABLE, 1'b0, 1'b1, 1'b0);
        wait_idle();

        // enabled without credentials: connect refused, ticks only count
        apply_config(1'b1, 16'd2, 8'd1, 1'b1, 1'b0);
        queue_req(REQ_ENABLE, 1'b1, 1'b0, 1'b0);
        queue_req(REQ_CONNECT_NOW, 1'b0, 1'b1, 1'b1);
        queue_req(REQ_TICK, 1'b0, 1'b0, 1'b1);
        queue_req(REQ_TICK, 1'b0, 1'b0, 1'b1);
        wait_idle();

        // failed retry, retries exhausted into access point, then recovery
        apply_config(1'b1, 16'd2, 8'd1, 1'b1, 1'b1);
        queue_req(REQ_TICK, 1'b0, 1'b0, 1'b0);
        queue_req(REQ_TICK, 1'b0, 1'b0, 1'b0);
        queue_req(REQ_TICK, 1'b0, 1'b0, 1'b1);
        queue_req(REQ_LINK_LOST, 1'b0, 1'b0, 1'b0);
        queue_req(REQ_TICK, 1'b0, 1'b1, 1'b1);
        queue_req(REQ_RESET_RETRIES, 1'b0, 1'b0, 1'b0);
        queue_req(REQ_DISCONNECT, 1'b0, 1'b0, 1'b0);
        queue_req(REQ_CONNECT_NOW, 1'b0, 1'b1, 1'b1);
        queue_req(REQ_TICK, 1'b0, 1'b1, 1'b0);
        queue_req(REQ_TICK, 1'b0, 1'b0, 1'b1);
        queue_req(REQ_LINK_LOST, 1'b0, 1'b1, 1'b0);
        queue_req(REQ_ENABLE, 1'b0, 1'b0, 1'b0);
        wait_idle();

        // seconds counter held at its ceiling
        apply_config(1'b1, 16'hFFFF, 8'hFF, 1'b0, 1'b0);
        queue_req(REQ_ENABLE, 1'b1, 1'b0, 1'b0);
        queue_req(REQ_LINK_LOST, 1'b0, 1'b0, 1'b0);
        queue_req(REQ_TICK, 1'b0, 1'b0, 1'b0);
        queue_req(REQ_TICK, 1'b0, 1'b0, 1'b0);
        wait_idle();
        apply_config(1'b1, 16'hFFFF, 8'hFF, 1'b0, 1'b1);
        queue_req(REQ_TICK, 1'b0, 1'b1, 1'b1);
        wait_idle();

        // random phases, extremes of the registers first
        for (int k = 0; k < RAND_PHASES; k++)
        begin
            pick = $urandom_range(0, 9);
            if (k == 0)
                interval = 16'd0;
            else if (k == 1)
                interval = 16'hFFFF;
            else if (pick < 6)
                interval = 16'($urandom_range(0, 4));
            else if (pick == 6)
                interval = 16'($urandom_range(5, 40));
            else if (pick == 7)
                interval = 16'hFFFF;
            else if (pick == 8)
                interval = 16'hFFFE;
            else
                interval = 16'($urandom());
            pick = $urandom_range(0, 9);
            if (k == 0)
                max_r = 8'd0;
            else if (k == 1)
                max_r = 8'hFF;
            else if (pick < 7)
                max_r = 8'($urandom_range(0, 6));
            else if (pick == 7)
                max_r = 8'hFF;
            else
                max_r = 8'($urandom());
            apply_config((k != 2) && ($urandom_range(0, 7) != 0), interval, max_r,
                         1'($urandom()), ($urandom_range(0, 4) != 0));
            queue_random_phase(PHASE_ITEMS, (k % 5) == 4);
            wait_idle();
        end

        repeat (8) @(posedge clk);
        if (expected_status.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time,
                     expected_status.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
